FILE: rtl/core/lr_pkg.sv
// Shared constants, codes and control types of the line rasterizer.
package lr_pkg;

    // Coordinate and derived widths
    localparam int COORD_BITS = 12;
    localparam int STEP_W     = COORD_BITS + 1;
    localparam int REM_W      = COORD_BITS + 2;
    localparam int ALU_W      = COORD_BITS + 4;
    localparam int DIM_BITS   = 11;
    localparam int CFG_IDX_W  = 1;

    // Frame size after reset
    localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RST  = DIM_BITS'(640);
    localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RST = DIM_BITS'(480);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    // Request opcodes
    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DX,
        ST_DY,
        ST_ADX,
        ST_ADY,
        ST_CMP,
        ST_MAJ,
        ST_MIN,
        ST_BX,
        ST_BY,
        ST_LAST,
        ST_ACC,
        ST_WRAP,
        ST_OUT
    } t_state;

    // Operation placed on the shared adder in a cycle
    typedef enum logic [3:0] {
        ALU_NONE,
        ALU_DX,
        ALU_DY,
        ALU_ADX,
        ALU_ADY,
        ALU_CMP,
        ALU_MAJ,
        ALU_MIN,
        ALU_BX,
        ALU_BY,
        ALU_LAST,
        ALU_ACC,
        ALU_WRAP
    } t_alu_sel;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic in_accept;
        logic op_start;
        logic line_active;
        logic out_ready;
    } t_status;

    // Sequencer controls to the datapath
    typedef struct packed {
        logic     in_ready;
        logic     out_valid;
        t_alu_sel alu_sel;
    } t_ctrl;

endpackage

FILE: rtl/core/lr_alu.sv
// Shared add/subtract unit with sign and zero flags.
module lr_alu (
    input  logic signed [lr_pkg::ALU_W-1:0] i_a,
    input  logic signed [lr_pkg::ALU_W-1:0] i_b,
    input  logic                            i_sub,
    output logic signed [lr_pkg::ALU_W-1:0] o_res,
    output logic                            o_neg,
    output logic                            o_zero
);

    logic [lr_pkg::ALU_W-1:0] b_op;

    // Invert and carry in for subtract
    assign b_op   = i_sub ? ~i_b : i_b;
    assign o_res  = i_a + b_op + {{(lr_pkg::ALU_W-1){1'b0}}, i_sub};
    assign o_neg  = o_res[lr_pkg::ALU_W-1];
    assign o_zero = (o_res == '0);

endmodule

FILE: rtl/core/lr_seq.sv
// Sequencer that steps the shared adder through setup and per-pixel work.
module lr_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lr_pkg::t_status i_status,
    output lr_pkg::t_ctrl   o_ctrl
);

    lr_pkg::t_state r_state;
    lr_pkg::t_state n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lr_pkg::ST_IDLE: begin
                if (i_status.in_accept) begin
                    if (i_status.op_start) begin
                        n_state = lr_pkg::ST_DX;
                    end else if (i_status.line_active) begin
                        n_state = lr_pkg::ST_MAJ;
                    end
                end
            end
            lr_pkg::ST_DX:   n_state = lr_pkg::ST_DY;
            lr_pkg::ST_DY:   n_state = lr_pkg::ST_ADX;
            lr_pkg::ST_ADX:  n_state = lr_pkg::ST_ADY;
            lr_pkg::ST_ADY:  n_state = lr_pkg::ST_CMP;
            lr_pkg::ST_CMP:  n_state = lr_pkg::ST_IDLE;
            lr_pkg::ST_MAJ:  n_state = lr_pkg::ST_MIN;
            lr_pkg::ST_MIN:  n_state = lr_pkg::ST_BX;
            lr_pkg::ST_BX:   n_state = lr_pkg::ST_BY;
            lr_pkg::ST_BY:   n_state = lr_pkg::ST_LAST;
            lr_pkg::ST_LAST: n_state = lr_pkg::ST_ACC;
            lr_pkg::ST_ACC:  n_state = lr_pkg::ST_WRAP;
            lr_pkg::ST_WRAP: n_state = lr_pkg::ST_OUT;
            lr_pkg::ST_OUT: begin
                if (i_status.out_ready) begin
                    n_state = lr_pkg::ST_IDLE;
                end
            end
            default: n_state = lr_pkg::ST_IDLE;
        endcase
    end

    // Decode controls
    always_comb begin
        o_ctrl.in_ready  = (r_state == lr_pkg::ST_IDLE);
        o_ctrl.out_valid = (r_state == lr_pkg::ST_OUT);
        case (r_state)
            lr_pkg::ST_DX:   o_ctrl.alu_sel = lr_pkg::ALU_DX;
            lr_pkg::ST_DY:   o_ctrl.alu_sel = lr_pkg::ALU_DY;
            lr_pkg::ST_ADX:  o_ctrl.alu_sel = lr_pkg::ALU_ADX;
            lr_pkg::ST_ADY:  o_ctrl.alu_sel = lr_pkg::ALU_ADY;
            lr_pkg::ST_CMP:  o_ctrl.alu_sel = lr_pkg::ALU_CMP;
            lr_pkg::ST_MAJ:  o_ctrl.alu_sel = lr_pkg::ALU_MAJ;
            lr_pkg::ST_MIN:  o_ctrl.alu_sel = lr_pkg::ALU_MIN;
            lr_pkg::ST_BX:   o_ctrl.alu_sel = lr_pkg::ALU_BX;
            lr_pkg::ST_BY:   o_ctrl.alu_sel = lr_pkg::ALU_BY;
            lr_pkg::ST_LAST: o_ctrl.alu_sel = lr_pkg::ALU_LAST;
            lr_pkg::ST_ACC:  o_ctrl.alu_sel = lr_pkg::ALU_ACC;
            lr_pkg::ST_WRAP: o_ctrl.alu_sel = lr_pkg::ALU_WRAP;
            default:         o_ctrl.alu_sel = lr_pkg::ALU_NONE;
        endcase
    end

endmodule

FILE: rtl/core/line_rasterizer.sv
// Line rasterizer top level: endpoint setup, incremental minor-axis stepping, frame test.
//
// A start request latches two endpoints and makes 5 passes through the shared
// adder, then is ready again; it gives no pixel. Each advance request of an
// active line takes 7 adder passes (major coordinate, minor coordinate, x and y
// frame tests, last-pixel test, remainder add, remainder wrap), then holds the
// pixel on the output until taken, after which the block is ready again. An
// advance with no active line is accepted and dropped. The single adder sets
// these pass counts.
// The minor coordinate follows a quotient and remainder of
// (2*|dminor|*k + dmajor) / (2*dmajor), updated by one add and one
// compare-subtract per pixel, so no divider is needed.
module line_rasterizer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // request channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_opcode,
    input  logic signed [lr_pkg::COORD_BITS-1:0] i_first_x,
    input  logic signed [lr_pkg::COORD_BITS-1:0] i_first_y,
    input  logic signed [lr_pkg::COORD_BITS-1:0] i_second_x,
    input  logic signed [lr_pkg::COORD_BITS-1:0] i_second_y,
    // pixel channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [lr_pkg::COORD_BITS-1:0] o_pixel_x,
    output logic signed [lr_pkg::COORD_BITS-1:0] o_pixel_y,
    output logic                                 o_pixel_inside,
    output logic                                 o_all_inside,
    output logic                                 o_last_pixel,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [lr_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [lr_pkg::DIM_BITS-1:0]          i_cfg_data
);

    localparam int CB = lr_pkg::COORD_BITS;
    localparam int AW = lr_pkg::ALU_W;

    lr_pkg::t_status status;
    lr_pkg::t_ctrl   ctrl;

    // Frame size
    logic [lr_pkg::DIM_BITS-1:0] r_frame_width;
    logic [lr_pkg::DIM_BITS-1:0] r_frame_height;

    // Latched endpoints and setup values
    logic signed [CB-1:0] r_fx, r_fy, r_sx, r_sy;
    logic signed [CB:0]   r_dx, r_dy;
    logic [CB-1:0]        r_adx, r_ady;

    // Line state
    logic                         r_line_active;
    logic                         r_major_is_x;
    logic signed [CB-1:0]         r_low_major;
    logic signed [CB-1:0]         r_low_minor;
    logic [CB-1:0]                r_dmaj;
    logic [CB-1:0]                r_dmin;
    logic                         r_minor_neg;
    logic [lr_pkg::STEP_W-1:0]    r_step;
    logic [lr_pkg::REM_W-1:0]     r_rem;
    logic [CB-1:0]                r_quo;
    logic                         r_inside_so_far;

    // Current pixel
    logic signed [CB-1:0] r_pmaj, r_pmin;
    logic                 r_in_x, r_in_y;

    // Output registers
    logic signed [CB-1:0] r_pixel_x, r_pixel_y;
    logic                 r_pixel_inside, r_all_inside, r_last_pixel;

    // Shared adder
    logic signed [AW-1:0] alu_a, alu_b, alu_res;
    logic                 alu_sub, alu_neg, alu_zero;

    // Setup decisions
    logic                 cmp_major_x, cmp_swap, raw_min_neg, raw_min_pos;
    logic signed [CB-1:0] px, py;
    logic                 pix_inside;

    assign status.in_accept   = i_in_valid & ctrl.in_ready;
    assign status.op_start    = (i_opcode == lr_pkg::OP_START);
    assign status.line_active = r_line_active;
    assign status.out_ready   = i_out_ready;

    lr_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    lr_alu u_alu (
        .i_a    (alu_a),
        .i_b    (alu_b),
        .i_sub  (alu_sub),
        .o_res  (alu_res),
        .o_neg  (alu_neg),
        .o_zero (alu_zero)
    );

    // Map pixel to x and y
    assign px = r_major_is_x ? r_pmaj : r_pmin;
    assign py = r_major_is_x ? r_pmin : r_pmaj;
    assign pix_inside = r_in_x & r_in_y;

    // Pick major axis and endpoint order from the compare pass
    assign cmp_major_x = alu_neg;
    assign cmp_swap    = cmp_major_x ? r_dx[CB] : r_dy[CB];
    assign raw_min_neg = cmp_major_x ? r_dy[CB] : r_dx[CB];
    assign raw_min_pos = cmp_major_x ? (!r_dy[CB] && (r_dy != '0))
                                     : (!r_dx[CB] && (r_dx != '0));

    // Steer operands onto the adder
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (ctrl.alu_sel)
            lr_pkg::ALU_DX: begin
                alu_a   = AW'(r_sx);
                alu_b   = AW'(r_fx);
                alu_sub = 1'b1;
            end
            lr_pkg::ALU_DY: begin
                alu_a   = AW'(r_sy);
                alu_b   = AW'(r_fy);
                alu_sub = 1'b1;
            end
            lr_pkg::ALU_ADX: begin
                alu_b   = AW'(r_dx);
                alu_sub = r_dx[CB];
            end
            lr_pkg::ALU_ADY: begin
                alu_b   = AW'(r_dy);
                alu_sub = r_dy[CB];
            end
            lr_pkg::ALU_CMP: begin
                alu_a   = AW'(r_ady);
                alu_b   = AW'(r_adx);
                alu_sub = 1'b1;
            end
            lr_pkg::ALU_MAJ: begin
                alu_a   = AW'(r_low_major);
                alu_b   = AW'(r_step);
            end
            lr_pkg::ALU_MIN: begin
                alu_a   = AW'(r_low_minor);
                alu_b   = AW'(r_quo);
                alu_sub = r_minor_neg;
            end
            lr_pkg::ALU_BX: begin
                alu_a   = AW'(px);
                alu_b   = AW'(r_frame_width);
                alu_sub = 1'b1;
            end
            lr_pkg::ALU_BY: begin
                alu_a   = AW'(py);
                alu_b   = AW'(r_frame_height);
                alu_sub = 1'b1;
            end
            lr_pkg::ALU_LAST: begin
                alu_a   = AW'(r_dmaj);
                alu_b   = AW'(r_step);
                alu_sub = 1'b1;
            end
            lr_pkg::ALU_ACC: begin
                alu_a   = AW'(r_rem);
                alu_b   = AW'({r_dmin, 1'b0});
            end
            lr_pkg::ALU_WRAP: begin
                alu_a   = AW'(r_rem);
                alu_b   = AW'({r_dmaj, 1'b0});
                alu_sub = 1'b1;
            end
            default: begin
                alu_a   = '0;
            end
        endcase
    end

    // Control registers: frame size, line activity, running flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width   <= lr_pkg::FRAME_WIDTH_RST;
            r_frame_height  <= lr_pkg::FRAME_HEIGHT_RST;
            r_line_active   <= 1'b0;
            r_inside_so_far <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lr_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                    lr_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (ctrl.alu_sel == lr_pkg::ALU_CMP) begin
                r_line_active   <= 1'b1;
                r_inside_so_far <= 1'b1;
            end else if (ctrl.alu_sel == lr_pkg::ALU_LAST) begin
                r_inside_so_far <= r_inside_so_far & pix_inside;
                if (alu_zero) begin
                    r_line_active <= 1'b0;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (status.in_accept && status.op_start) begin
            r_fx <= i_first_x;
            r_fy <= i_first_y;
            r_sx <= i_second_x;
            r_sy <= i_second_y;
        end
        case (ctrl.alu_sel)
            lr_pkg::ALU_DX:  r_dx  <= alu_res[CB:0];
            lr_pkg::ALU_DY:  r_dy  <= alu_res[CB:0];
            lr_pkg::ALU_ADX: r_adx <= alu_res[CB-1:0];
            lr_pkg::ALU_ADY: r_ady <= alu_res[CB-1:0];
            lr_pkg::ALU_CMP: begin
                r_major_is_x <= cmp_major_x;
                if (cmp_major_x) begin
                    r_low_major <= cmp_swap ? r_sx : r_fx;
                    r_low_minor <= cmp_swap ? r_sy : r_fy;
                    r_dmaj      <= r_adx;
                    r_dmin      <= r_ady;
                    r_rem       <= lr_pkg::REM_W'(r_adx);
                end else begin
                    r_low_major <= cmp_swap ? r_sy : r_fy;
                    r_low_minor <= cmp_swap ? r_sx : r_fx;
                    r_dmaj      <= r_ady;
                    r_dmin      <= r_adx;
                    r_rem       <= lr_pkg::REM_W'(r_ady);
                end
                r_minor_neg <= cmp_swap ? raw_min_pos : raw_min_neg;
                r_step      <= '0;
                r_quo       <= '0;
            end
            lr_pkg::ALU_MAJ: r_pmaj <= alu_res[CB-1:0];
            lr_pkg::ALU_MIN: r_pmin <= alu_res[CB-1:0];
            lr_pkg::ALU_BX:  r_in_x <= !px[CB-1] && alu_neg;
            lr_pkg::ALU_BY:  r_in_y <= !py[CB-1] && alu_neg;
            lr_pkg::ALU_LAST: begin
                r_pixel_x      <= px;
                r_pixel_y      <= py;
                r_pixel_inside <= pix_inside;
                r_all_inside   <= r_inside_so_far & pix_inside;
                r_last_pixel   <= alu_zero;
                if (!alu_zero) begin
                    r_step <= r_step + 1'b1;
                end
            end
            lr_pkg::ALU_ACC: r_rem <= alu_res[lr_pkg::REM_W-1:0];
            lr_pkg::ALU_WRAP: begin
                // once the remainder reaches 2*dmajor, drop one period and advance the quotient
                if (!alu_neg) begin
                    r_rem <= alu_res[lr_pkg::REM_W-1:0];
                    r_quo <= r_quo + 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_in_ready     = ctrl.in_ready;
    assign o_out_valid    = ctrl.out_valid;
    assign o_pixel_x      = r_pixel_x;
    assign o_pixel_y      = r_pixel_y;
    assign o_pixel_inside = r_pixel_inside;
    assign o_all_inside   = r_all_inside;
    assign o_last_pixel   = r_last_pixel;

    // Block frees up the cycle after a pixel is taken
    a_ready_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |=> o_in_ready)
        else $error("not ready after pixel taken");

    // Step index never runs past the line length
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_active |-> (r_step <= lr_pkg::STEP_W'(r_dmaj)))
        else $error("step index beyond line end");

    // Remainder stays reduced between pixels
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && r_line_active && (r_dmaj != '0))
            |-> (r_rem < lr_pkg::REM_W'({r_dmaj, 1'b0})))
        else $error("remainder not reduced");

    // Last pixel ends the line
    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_pixel) |-> !r_line_active)
        else $error("line still active after last pixel");

    // Running flag never exceeds the pixel flag
    a_all_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_all_inside) |-> o_pixel_inside)
        else $error("running inside flag set on outside pixel");

endmodule
